/* rtl/biq_pkg.sv */
`timescale 1ns / 1ps

package biq_pkg;

  // Data path sizing.
  localparam int SAMPLE_WIDTH   = 24;
  localparam int COEF_WIDTH     = 32;
  localparam int COEF_FRAC_BITS = 28;

  // A full product, and the sum of five products plus the rounding constant.
  localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 3;
  // The rounded sum after the fraction bits are dropped.
  localparam int RND_WIDTH  = ACC_WIDTH - COEF_FRAC_BITS;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;
  localparam cfg_index_t REG_COEF_B0 = CFG_INDEX_WIDTH'(0);
  localparam cfg_index_t REG_COEF_B1 = CFG_INDEX_WIDTH'(1);
  localparam cfg_index_t REG_COEF_B2 = CFG_INDEX_WIDTH'(2);
  localparam cfg_index_t REG_COEF_A1 = CFG_INDEX_WIDTH'(3);
  localparam cfg_index_t REG_COEF_A2 = CFG_INDEX_WIDTH'(4);

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [PROD_WIDTH-1:0]   prod_t;
  typedef logic signed [ACC_WIDTH-1:0]    acc_t;
  typedef logic signed [RND_WIDTH-1:0]    rnd_t;

  // Unity gain on the current input after reset.
  localparam coef_t COEF_ONE = coef_t'(1) <<< COEF_FRAC_BITS;

  // Half an output LSB, added before the fraction bits are dropped.
  localparam acc_t RND_HALF = acc_t'(1) <<< (COEF_FRAC_BITS - 1);

  // Sample range limits used by the saturation stage.
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  // Current coefficient set, handed from the register bank to the datapath.
  typedef struct packed {
    coef_t b0;
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } coef_set_t;

  // Filter taps presented to the datapath.
  typedef struct packed {
    sample_t x;
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } taps_t;

  // One filtered word with its saturation flag.
  typedef struct packed {
    sample_t y;
    logic    clipped;
  } result_t;

endpackage

/* rtl/biq_ifs.sv */
`timescale 1ns / 1ps

// Input sample channel.
interface biq_in_if;
  logic                valid;
  logic                ready;
  biq_pkg::sample_t    in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// Filtered sample channel.
interface biq_out_if;
  logic                valid;
  logic                ready;
  biq_pkg::sample_t    out_sample;
  logic                clipped;

  modport source (output valid, output out_sample, output clipped, input ready);
  modport sink   (input valid, input out_sample, input clipped, output ready);
endinterface

// Coefficient write channel.
interface biq_cfg_if;
  logic                  valid;
  logic                  ready;
  biq_pkg::cfg_index_t   index;
  biq_pkg::coef_t        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/biq_coef_bank.sv */
`timescale 1ns / 1ps

module biq_coef_bank (
  input  logic                clk,
  input  logic                rst,
  biq_cfg_if.sink             cfg,
  output biq_pkg::coef_set_t  coefs
);

  biq_pkg::coef_set_t coef_regs;
  biq_pkg::coef_set_t coef_regs_next;

  // Writes are always taken; an index past the last register is dropped.
  assign cfg.ready = 1'b1;

  // Register decode.
  always_comb begin
    coef_regs_next = coef_regs;
    if (cfg.valid) begin
      unique case (cfg.index)
        biq_pkg::REG_COEF_B0: coef_regs_next.b0 = cfg.data;
        biq_pkg::REG_COEF_B1: coef_regs_next.b1 = cfg.data;
        biq_pkg::REG_COEF_B2: coef_regs_next.b2 = cfg.data;
        biq_pkg::REG_COEF_A1: coef_regs_next.a1 = cfg.data;
        biq_pkg::REG_COEF_A2: coef_regs_next.a2 = cfg.data;
        default:              coef_regs_next = coef_regs;
      endcase
    end
  end

  // Coefficient storage; a pass-through filter after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_regs.b0 <= biq_pkg::COEF_ONE;
      coef_regs.b1 <= '0;
      coef_regs.b2 <= '0;
      coef_regs.a1 <= '0;
      coef_regs.a2 <= '0;
    end else begin
      coef_regs <= coef_regs_next;
    end
  end

  assign coefs = coef_regs;

endmodule

/* rtl/biq_mac.sv */
`timescale 1ns / 1ps

module biq_mac (
  input  biq_pkg::coef_set_t  coefs,
  input  biq_pkg::taps_t      taps,
  output biq_pkg::result_t    result
);

  biq_pkg::prod_t prod_b0;
  biq_pkg::prod_t prod_b1;
  biq_pkg::prod_t prod_b2;
  biq_pkg::prod_t prod_a1;
  biq_pkg::prod_t prod_a2;
  biq_pkg::acc_t  acc;
  biq_pkg::rnd_t  rnd;
  logic [biq_pkg::RND_WIDTH-biq_pkg::SAMPLE_WIDTH:0] rnd_top;
  logic           fits;

  // Five independent full-precision products.
  assign prod_b0 = biq_pkg::prod_t'(coefs.b0) * biq_pkg::prod_t'(taps.x);
  assign prod_b1 = biq_pkg::prod_t'(coefs.b1) * biq_pkg::prod_t'(taps.x1);
  assign prod_b2 = biq_pkg::prod_t'(coefs.b2) * biq_pkg::prod_t'(taps.x2);
  assign prod_a1 = biq_pkg::prod_t'(coefs.a1) * biq_pkg::prod_t'(taps.y1);
  assign prod_a2 = biq_pkg::prod_t'(coefs.a2) * biq_pkg::prod_t'(taps.y2);

  // Exact sum with half an LSB added, so the truncation below rounds to nearest
  // with ties going up.
  assign acc = biq_pkg::acc_t'(prod_b0) + biq_pkg::acc_t'(prod_b1)
             + biq_pkg::acc_t'(prod_b2) - biq_pkg::acc_t'(prod_a1)
             - biq_pkg::acc_t'(prod_a2) + biq_pkg::RND_HALF;

  // Dropping the fraction bits is an arithmetic shift right.
  assign rnd = acc[biq_pkg::ACC_WIDTH-1:biq_pkg::COEF_FRAC_BITS];

  // The value fits when every bit from the sample sign bit upward agrees.
  assign rnd_top = rnd[biq_pkg::RND_WIDTH-1:biq_pkg::SAMPLE_WIDTH-1];
  assign fits    = (rnd_top == '0) || (rnd_top == '1);

  // Saturate out-of-range sums to the nearest limit.
  always_comb begin
    result.clipped = !fits;
    if (fits) begin
      result.y = rnd[biq_pkg::SAMPLE_WIDTH-1:0];
    end else if (rnd[biq_pkg::RND_WIDTH-1]) begin
      result.y = biq_pkg::SAMPLE_MIN;
    end else begin
      result.y = biq_pkg::SAMPLE_MAX;
    end
  end

endmodule

/* rtl/biquad_iir_filter_unit.sv */
`timescale 1ns / 1ps
// Direct form I biquad section, one sample per cycle sustained while the
// output channel is not stalled. An accepted word passes through the input
// register, then the result register, to the output channel.
// The critical path is the feedback loop: five parallel multipliers, the
// adder, rounding and saturation back into the previous-output register.
// Reset (rst, synchronous) empties both stages, clears the sample history
// and loads a unity pass-through coefficient set.

module biquad_iir_filter_unit (
  input  logic       clk,
  input  logic       rst,
  biq_in_if.sink     audio,
  biq_out_if.source  filtered,
  biq_cfg_if.sink    cfg
);

  biq_pkg::coef_set_t coefs;
  biq_pkg::taps_t     taps;
  biq_pkg::result_t   mac_result;

  logic               s1_valid;
  biq_pkg::sample_t   s1_x;
  biq_pkg::sample_t   x_prev1;
  biq_pkg::sample_t   x_prev2;
  biq_pkg::sample_t   y_prev1;
  biq_pkg::sample_t   y_prev2;
  logic               out_valid;
  biq_pkg::result_t   out_word;
  logic               advance;

  biq_coef_bank u_coef_bank (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .coefs (coefs)
  );

  assign taps.x  = s1_x;
  assign taps.x1 = x_prev1;
  assign taps.x2 = x_prev2;
  assign taps.y1 = y_prev1;
  assign taps.y2 = y_prev2;

  biq_mac u_mac (
    .coefs  (coefs),
    .taps   (taps),
    .result (mac_result)
  );

  // The held word moves to the result register when that register is free
  // or is being emptied in this cycle.
  assign advance     = s1_valid && (!out_valid || filtered.ready);
  assign audio.ready = !s1_valid || advance;

  // Stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (audio.ready) begin
        s1_valid <= audio.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (filtered.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sample history advances only as a word is filtered.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_prev1 <= '0;
      x_prev2 <= '0;
      y_prev1 <= '0;
      y_prev2 <= '0;
    end else if (advance) begin
      x_prev1 <= s1_x;
      x_prev2 <= x_prev1;
      y_prev1 <= mac_result.y;
      y_prev2 <= y_prev1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (audio.valid && audio.ready) begin
      s1_x <= audio.in_sample;
    end
    if (advance) begin
      out_word <= mac_result;
    end
  end

  assign filtered.valid      = out_valid;
  assign filtered.out_sample = out_word.y;
  assign filtered.clipped    = out_word.clipped;

endmodule

/* rtl/biq_checker.sv */
`timescale 1ns / 1ps

module biq_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input biq_pkg::sample_t out_sample,
  input logic             clipped
);

  // Reset leaves no word on the output.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // A stalled output word must stay put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(clipped))
    else $error("stalled output word changed");

  // A clipped word carries one of the two range limits.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (out_sample == biq_pkg::SAMPLE_MAX) || (out_sample == biq_pkg::SAMPLE_MIN))
    else $error("clipped word is not at a range limit");

  // The input only stalls behind a full, blocked output stage.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output side can move");

endmodule

bind biquad_iir_filter_unit biq_checker u_biq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (audio.valid),
  .in_ready   (audio.ready),
  .out_valid  (filtered.valid),
  .out_ready  (filtered.ready),
  .out_sample (filtered.out_sample),
  .clipped    (filtered.clipped)
);
